// File: rtl/array_list_engine_defines.svh
// assertion helpers for the list engine sources
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// condition must hold in the same cycle
`define ALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the next cycle
`define ALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ale_pkg.sv
package ale_pkg;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_DONE
  } state_t;

  // command kinds
  localparam logic [3:0] KIND_CLEAR   = 4'd0;
  localparam logic [3:0] KIND_INSERT  = 4'd1;
  localparam logic [3:0] KIND_DELETE  = 4'd2;
  localparam logic [3:0] KIND_LOCATE  = 4'd3;
  localparam logic [3:0] KIND_DELMIN  = 4'd4;
  localparam logic [3:0] KIND_REVERSE = 4'd5;
  localparam logic [3:0] KIND_REMOVE  = 4'd6;
  localparam logic [3:0] KIND_SRANGE  = 4'd7;
  localparam logic [3:0] KIND_RANGE   = 4'd8;
  localparam logic [3:0] KIND_DEDUP   = 4'd9;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic pop;
    logic push;
  } cell_ctl_t;

endpackage

// File: rtl/ale_cell.sv
module ale_cell #(
  parameter int EW  = 32,
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  ale_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]     w,
  input  logic [EW-1:0]     next_data,
  input  logic [EW-1:0]     push_data,
  output logic [EW-1:0]     data
);
  import ale_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // below the write slot take the neighbor, at the slot take the pushed word
  always_ff @(posedge clk) begin
    if (ctl.pop && (MY_IDX < w)) begin
      data <= next_data;
    end else if (ctl.push && (MY_IDX == w)) begin
      data <= push_data;
    end
  end

endmodule

// File: rtl/array_list_engine.sv
// Ordered list engine: elements live in a row of CAPACITY cells, position 1 at cell 0.
// Each list command streams the list through cell 0: each cycle the head element is
// popped and either written back at a broadcast slot (the tail, or a moving slot for
// reverse) or dropped; insert pushes the new word at the tail when it reaches its spot.
// Delete min and sorted range removal first run a pass that finds the minimum or the
// range bounds before that move pass. Errors, clear and unused kinds skip both passes.
// A new request is taken only while the engine is idle; the result sits in an output
// register, so the next request can start while it waits to be taken.
`include "array_list_engine_defines.svh"

module array_list_engine #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         kind,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  input  logic signed [31:0] range_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] result_value,
  output logic [6:0]         found_position,
  output logic [6:0]         removed_count,
  output logic [6:0]         list_length
);
  import ale_pkg::*;

  localparam int EW = ELEMENT_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  state_t state, state_next;

  logic [EW-1:0]        cell_data [CAPACITY];
  logic signed [EW-1:0] head;
  cell_ctl_t            ctl;
  logic [IW-1:0]        w;
  logic signed [EW-1:0] push_data;

  logic [CW-1:0]        count, qlen, j, mi, first_idx, last_idx;
  logic [CW-1:0]        found_r, removed_r;
  logic [3:0]           kind_r;
  logic [6:0]           pos_r;
  logic signed [EW-1:0] s_r, t_r, res_r, minv, lastv, lastk;
  logic [1:0]           status_r;
  logic                 ins_done, first_found, have_kept;

  logic signed [EW-1:0] val_e, hi_e;
  logic [1:0]           start_status;
  logic                 accept, ins_now, keep, load_out, last_elem;

  assign val_e = EW'(value);
  assign hi_e  = EW'(range_high);
  assign head  = cell_data[0];

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [EW-1:0] nb;
    if (g == CAPACITY - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_data[g + 1];
    end
    ale_cell #(.EW(EW), .IW(IW), .IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .w         (w),
      .next_data (nb),
      .push_data (push_data),
      .data      (cell_data[g])
    );
  end

  // request checks against the current length
  always_comb begin
    start_status = STAT_OK;
    case (kind)
      KIND_INSERT: begin
        if (position == 7'd0 || PW'(position) > PW'(count) + PW'(1)) begin
          start_status = STAT_BAD_POS;
        end else if (count == CW'(CAPACITY)) begin
          start_status = STAT_FULL;
        end
      end
      KIND_DELETE: begin
        if (position == 7'd0 || PW'(position) > PW'(count)) begin
          start_status = STAT_BAD_POS;
        end
      end
      KIND_DELMIN: begin
        if (count == '0) begin
          start_status = STAT_EMPTY;
        end
      end
      KIND_SRANGE, KIND_RANGE: begin
        if (count == '0 || val_e >= hi_e) begin
          start_status = STAT_EMPTY;
        end
      end
      default: start_status = STAT_OK;
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_elem = (j == count - 1'b1);

  // keep or drop the head element during the move pass
  always_comb begin
    keep = 1'b1;
    case (kind_r)
      KIND_DELETE: keep = (PW'(j) + PW'(1) != PW'(pos_r));
      KIND_DELMIN: keep = !last_elem;
      KIND_REMOVE: keep = (head != s_r);
      KIND_SRANGE: keep = !(first_found && j >= first_idx && j < last_idx);
      KIND_RANGE:  keep = !(head >= s_r && head <= t_r);
      KIND_DEDUP:  keep = !have_kept || (head != lastk);
      default:     keep = 1'b1;
    endcase
  end

  assign ins_now = (kind_r == KIND_INSERT) && !ins_done && (PW'(j) + PW'(1) == PW'(pos_r));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and cell commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    w          = '0;
    push_data  = head;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (start_status != STAT_OK || kind == KIND_CLEAR || kind > KIND_DEDUP) begin
            state_next = ST_DONE;
          end else if (kind == KIND_DELMIN || kind == KIND_SRANGE) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_MOVE;
          end
        end
      end
      ST_SCAN: begin
        ctl.pop  = 1'b1;
        ctl.push = 1'b1;
        w        = IW'(qlen - 1'b1);
        if (last_elem) begin
          state_next = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (ins_now) begin
          ctl.push  = 1'b1;
          w         = IW'(qlen);
          push_data = s_r;
        end else if (j < count) begin
          ctl.pop  = 1'b1;
          ctl.push = keep;
          if (kind_r == KIND_REVERSE) begin
            w = IW'(count - j - 1'b1);
          end else begin
            w = IW'(qlen - 1'b1);
          end
          if (kind_r == KIND_DELMIN && j == mi) begin
            push_data = lastv;
          end
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= kind;
      pos_r       <= position;
      s_r         <= val_e;
      t_r         <= hi_e;
      status_r    <= start_status;
      res_r       <= '0;
      found_r     <= '0;
      removed_r   <= '0;
      j           <= '0;
      ins_done    <= 1'b0;
      first_found <= 1'b0;
      first_idx   <= '0;
      last_idx    <= '0;
      have_kept   <= 1'b0;
    end else if (state == ST_SCAN) begin
      j <= last_elem ? '0 : j + 1'b1;
      if (j == '0 || head < minv) begin
        minv <= head;
        mi   <= j;
      end
      if (last_elem) begin
        lastv <= head;
      end
      if (!first_found && head >= s_r) begin
        first_found <= 1'b1;
        first_idx   <= j;
      end
      if ((first_found || head >= s_r) && head <= t_r) begin
        last_idx <= j + 1'b1;
      end
    end else if (state == ST_MOVE) begin
      if (ins_now) begin
        ins_done <= 1'b1;
      end else if (j < count) begin
        j <= j + 1'b1;
        if (!keep && kind_r >= KIND_REMOVE && kind_r <= KIND_DEDUP) begin
          removed_r <= removed_r + 1'b1;
        end
        if (kind_r == KIND_DELETE && !keep) begin
          res_r <= head;
        end
        if (kind_r == KIND_DELMIN && last_elem) begin
          res_r <= minv;
        end
        if (kind_r == KIND_LOCATE && found_r == '0 && head == s_r) begin
          found_r <= j + 1'b1;
        end
        if (kind_r == KIND_DEDUP && keep) begin
          lastk     <= head;
          have_kept <= 1'b1;
        end
      end
    end
  end

  // lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      qlen  <= '0;
    end else begin
      if (accept && kind == KIND_CLEAR) begin
        qlen <= '0;
      end else if (state == ST_MOVE && ins_now) begin
        qlen <= qlen + 1'b1;
      end else if (state == ST_MOVE && j < count && !keep) begin
        qlen <= qlen - 1'b1;
      end
      if (load_out) begin
        count <= qlen;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= status_r;
      result_value   <= 32'(res_r);
      found_position <= 7'(found_r);
      removed_count  <= 7'(removed_r);
      list_length    <= 7'(qlen);
    end
  end

  `ALE_ASSERT_NOW(a_len_bound, 1'b1, qlen <= CW'(CAPACITY), "list length beyond capacity")
  `ALE_ASSERT_NOW(a_idle_len, state == ST_IDLE, qlen == count, "length not committed in idle")
  `ALE_ASSERT_NOW(a_pop_nonempty, ctl.pop, qlen != '0, "pop from an empty row")
  `ALE_ASSERT_NEXT(a_load_idle, load_out, state == ST_IDLE && out_valid, "result not posted")

endmodule
